@@ design/rbaf_pkg.sv @@
// ----------------------------------------------------------------------------
// Row box average filter package
// Shared widths, register indexes, controller states and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package rbaf_pkg;

  localparam int PIX_W   = 8;
  localparam int PIX_MAX = 255;
  localparam int ROW_W   = 13;
  localparam int WIN_W   = 5;
  localparam int CFG_W   = 13;
  localparam int IDX_W   = 1;
  localparam int QI_W    = $clog2(PIX_W);

  localparam logic [ROW_W-1:0] ROW_WIDTH_RST   = ROW_W'(256);
  localparam logic [WIN_W-1:0] WINDOW_SIZE_RST = WIN_W'(4);

  typedef enum logic [IDX_W-1:0] {
    REG_ROW_WIDTH   = 1'b0,
    REG_WINDOW_SIZE = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_DELIVER
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_step;
    logic deliver;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic zero_win;
    logic due;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

@@ design/rbaf_div.sv @@
// ----------------------------------------------------------------------------
// Row box average filter divider
// Restoring divider that produces one quotient bit per step, most
// significant bit first. The quotient is known to fit in one pixel.
// ----------------------------------------------------------------------------
module rbaf_div #(
  parameter int SW = 12,
  parameter int WW = 5
) (
  input  logic                       clk,
  input  logic                       start,
  input  logic                       step,
  input  logic [SW-1:0]              dividend,
  input  logic [WW-1:0]              divisor,
  output logic [rbaf_pkg::PIX_W-1:0] quotient,
  output logic                       last_step
);

  localparam int DW = WW + rbaf_pkg::PIX_W - 1;
  localparam int TW = (SW > DW) ? SW : DW;

  logic [SW-1:0]              rem;
  logic [DW-1:0]              dsh;
  logic [rbaf_pkg::QI_W-1:0]  idx;
  logic [TW-1:0]              diff;
  logic                       ge;

  assign ge        = TW'(rem) >= TW'(dsh);
  assign diff      = TW'(rem) - TW'(dsh);
  assign last_step = idx == rbaf_pkg::QI_W'(rbaf_pkg::PIX_W - 1);

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dsh <= {divisor, {(rbaf_pkg::PIX_W - 1){1'b0}}};
      idx <= '0;
    end else if (step) begin
      if (ge) begin
        rem <= diff[SW-1:0];
      end
      quotient <= {quotient[rbaf_pkg::PIX_W-2:0], ge};
      dsh      <= dsh >> 1;
      idx      <= idx + rbaf_pkg::QI_W'(1);
    end
  end

endmodule

@@ design/rbaf_datapath.sv @@
// ----------------------------------------------------------------------------
// Row box average filter datapath
// Configuration registers, pixel window, running sum, column and retire
// counters, the divider and the output register.
// ----------------------------------------------------------------------------
module rbaf_datapath #(
  parameter int MAX_WINDOW = 16,
  parameter int MAX_WIDTH  = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [rbaf_pkg::IDX_W-1:0]    cfg_index,
  input  logic [rbaf_pkg::CFG_W-1:0]    cfg_data,
  input  logic [rbaf_pkg::PIX_W-1:0]    pixel_in,
  input  rbaf_pkg::cmd_t                cmd,
  output rbaf_pkg::status_t             status,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [rbaf_pkg::PIX_W-1:0]    smudged_pixel,
  output logic                          last_of_run
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (CW > rbaf_pkg::ROW_W) ? CW : rbaf_pkg::ROW_W;
  localparam int WW = $clog2(MAX_WINDOW + 1);
  localparam int XW = (WW > rbaf_pkg::WIN_W) ? WW : rbaf_pkg::WIN_W;
  localparam int NW = (CW > WW) ? CW : WW;
  localparam int SW = $clog2(MAX_WINDOW * rbaf_pkg::PIX_MAX + 1);
  localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [rbaf_pkg::ROW_W-1:0] row_width;
  logic [rbaf_pkg::WIN_W-1:0] window_size;
  logic [EW-1:0]              rw_ext;
  logic [EW-1:0]              eff_width;
  logic [XW-1:0]              ws_ext;
  logic [WW-1:0]              eff_win;

  logic [rbaf_pkg::PIX_W-1:0] window_store [MAX_WINDOW];
  logic [SW-1:0]              running_sum;
  logic [CW-1:0]              column_count;
  logic [CW-1:0]              emitted_count;
  logic [PW-1:0]              wr_ptr;
  logic [PW-1:0]              rd_ptr;
  logic                       row_end;
  logic                       last_flag;

  logic [NW-1:0]              pending;
  logic [rbaf_pkg::PIX_W-1:0] quotient;
  logic                       div_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width   <= rbaf_pkg::ROW_WIDTH_RST;
      window_size <= rbaf_pkg::WINDOW_SIZE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rbaf_pkg::REG_ROW_WIDTH:   row_width   <= cfg_data[rbaf_pkg::ROW_W-1:0];
        rbaf_pkg::REG_WINDOW_SIZE: window_size <= cfg_data[rbaf_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign rw_ext = EW'(row_width);
  assign ws_ext = XW'(window_size);

  always_comb begin
    if (rw_ext == '0) begin
      eff_width = EW'(1);
    end else if (rw_ext > EW'(MAX_WIDTH)) begin
      eff_width = EW'(MAX_WIDTH);
    end else begin
      eff_width = rw_ext;
    end
  end

  assign eff_win = (ws_ext > XW'(MAX_WINDOW)) ? WW'(MAX_WINDOW) : ws_ext[WW-1:0];

  assign pending = NW'(column_count) - NW'(emitted_count);

  assign status.zero_win = eff_win == '0;
  assign status.due      = (pending >= NW'(eff_win)) || (row_end && pending != '0);
  assign status.div_last = div_last;
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.accept && !status.zero_win) begin
      window_store[wr_ptr] <= pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      running_sum   <= '0;
      column_count  <= '0;
      emitted_count <= '0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      row_end       <= 1'b0;
    end else begin
      if (cmd.accept) begin
        column_count <= column_count + CW'(1);
        row_end      <= (EW'(column_count) + EW'(1)) == eff_width;
        if (!status.zero_win) begin
          running_sum <= running_sum + SW'(pixel_in);
          wr_ptr      <= (wr_ptr == PW'(MAX_WINDOW - 1)) ? '0 : wr_ptr + PW'(1);
        end
      end
      if (cmd.deliver && !status.zero_win) begin
        running_sum   <= running_sum - SW'(window_store[rd_ptr]);
        emitted_count <= emitted_count + CW'(1);
        rd_ptr        <= (rd_ptr == PW'(MAX_WINDOW - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (cmd.finish && row_end) begin
        running_sum   <= '0;
        column_count  <= '0;
        emitted_count <= '0;
        wr_ptr        <= '0;
        rd_ptr        <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      last_flag <= !(row_end && pending > NW'(1));
    end
  end

  rbaf_div #(
    .SW(SW),
    .WW(WW)
  ) u_div (
    .clk      (clk),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .dividend (running_sum),
    .divisor  (pending[WW-1:0]),
    .quotient (quotient),
    .last_step(div_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.deliver) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      smudged_pixel <= status.zero_win ? '0 : quotient;
      last_of_run   <= status.zero_win ? 1'b1 : last_flag;
    end
  end

endmodule

@@ design/rbaf_ctrl.sv @@
// ----------------------------------------------------------------------------
// Row box average filter controller
// Sequences one input word: accept, check for owed results, divide (not for
// a zero window) and deliver each one, then close the row when it has ended.
// ----------------------------------------------------------------------------
module rbaf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rbaf_pkg::status_t  status,
  output rbaf_pkg::cmd_t     cmd
);

  rbaf_pkg::state_t state;
  rbaf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbaf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rbaf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = rbaf_pkg::ST_CHECK;
        end
      end
      rbaf_pkg::ST_CHECK: begin
        if (status.zero_win) begin
          state_next = rbaf_pkg::ST_DELIVER;
        end else if (status.due) begin
          state_next = rbaf_pkg::ST_DIVIDE;
        end else begin
          state_next = rbaf_pkg::ST_IDLE;
        end
      end
      rbaf_pkg::ST_DIVIDE: begin
        if (status.div_last) begin
          state_next = rbaf_pkg::ST_DELIVER;
        end
      end
      rbaf_pkg::ST_DELIVER: begin
        if (status.out_free) begin
          state_next = status.zero_win ? rbaf_pkg::ST_IDLE : rbaf_pkg::ST_CHECK;
        end
      end
      default: state_next = rbaf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      rbaf_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      rbaf_pkg::ST_CHECK: begin
        cmd.div_start = !status.zero_win && status.due;
        cmd.finish    = !status.zero_win && !status.due;
      end
      rbaf_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      rbaf_pkg::ST_DELIVER: begin
        cmd.deliver = status.out_free;
        cmd.finish  = status.out_free && status.zero_win;
      end
      default: ;
    endcase
  end

endmodule

@@ design/row_box_average_filter.sv @@
// ----------------------------------------------------------------------------
// Row box average filter
// Horizontal moving average over a raster stream of grayscale pixels.
// ----------------------------------------------------------------------------
// Each result is the truncated mean of a pixel and the pixels to its right
// in the same row, with the window clipped at the row end. An input word
// that owes no result passes through the accept and check states. Every
// result adds a check, eight steps of the bit-serial divider and a load of
// the output register, held off while out_stall holds that register. A
// row-end pixel flushes up to window_size, at most MAX_WINDOW, results in
// one run. A zero window gives one result per word via accept, check and
// deliver. The next word is taken while the last result waits at output.
module row_box_average_filter #(
  parameter int MAX_WINDOW = 16,
  parameter int MAX_WIDTH  = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [rbaf_pkg::IDX_W-1:0]    cfg_index,
  input  logic [rbaf_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rbaf_pkg::PIX_W-1:0]    pixel_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rbaf_pkg::PIX_W-1:0]    smudged_pixel,
  output logic                          last_of_run
);

  rbaf_pkg::cmd_t    cmd;
  rbaf_pkg::status_t status;

  rbaf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  rbaf_datapath #(
    .MAX_WINDOW(MAX_WINDOW),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_in     (pixel_in),
    .cmd          (cmd),
    .status       (status),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .smudged_pixel(smudged_pixel),
    .last_of_run  (last_of_run)
  );

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice without processing");

  a_deliver_room: assert property (@(posedge clk) disable iff (rst)
    cmd.deliver |-> !(out_valid && out_stall))
    else $error("result loaded over a stalled word");

  a_deliver_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.deliver |=> out_valid)
    else $error("delivered result not presented");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.div_start, cmd.div_step, cmd.deliver}))
    else $error("conflicting datapath commands");

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// Row box average filter testbench
// Streams grayscale pixel words through the filter under several row widths
// and window sizes. Each accepted pixel is run through a local model of the
// moving average. That model gives the mean words and the end-of-run marks
// that the filter owes. Every output word is checked against the oldest
// word still owed. Both sides idle at random, and the receiver holds off
// once for a long stretch so that the filter backs up.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_CAP     = 16;
  localparam int WIDTH_CAP   = 4096;
  localparam int SETTLE      = 16;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [rbaf_pkg::PIX_W-1:0] mean;
    logic                       last;
  } mean_word_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [rbaf_pkg::IDX_W-1:0] cfg_index = rbaf_pkg::REG_ROW_WIDTH;
  logic [rbaf_pkg::CFG_W-1:0] cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic [rbaf_pkg::PIX_W-1:0] pixel_in  = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [rbaf_pkg::PIX_W-1:0] smudged_pixel;
  logic                       last_of_run;

  logic [rbaf_pkg::ROW_W-1:0] row_cfg;
  logic [rbaf_pkg::WIN_W-1:0] win_cfg;
  logic [rbaf_pkg::PIX_W-1:0] win_store [WIN_CAP];
  logic [11:0]                run_sum;
  logic [11:0]                col_cnt;
  logic [11:0]                emitted;

  logic [rbaf_pkg::PIX_W-1:0] pix_q [$];
  mean_word_t                 owed_q [$];

  logic in_took  = 1'b0;
  logic out_took = 1'b0;
  logic in_burst = 1'b0;
  logic out_burst = 1'b0;
  int   tx_gap = 0;
  int   rx_wait = 0;
  int   rx_next;
  int   hold_left = 0;
  int   holds_asked = 0;
  int   holds_served = 0;
  int   mismatches = 0;

  row_box_average_filter #(
    .MAX_WINDOW(WIN_CAP),
    .MAX_WIDTH (WIDTH_CAP)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel_in     (pixel_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .smudged_pixel(smudged_pixel),
    .last_of_run  (last_of_run)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void start_new_row();
    run_sum = '0;
    col_cnt = '0;
    emitted = '0;
  endfunction

  function automatic int eff_row();
    if (row_cfg == 0) begin
      return 1;
    end
    if (row_cfg > WIDTH_CAP) begin
      return WIDTH_CAP;
    end
    return int'(row_cfg);
  endfunction

  function automatic void retire_oldest(int n);
    mean_word_t w;
    w.mean = rbaf_pkg::PIX_W'(run_sum / n);
    w.last = 1'b0;
    owed_q.push_back(w);
    run_sum = run_sum - win_store[emitted % WIN_CAP];
    emitted = emitted + 1'b1;
  endfunction

  function automatic void predict_means(logic [rbaf_pkg::PIX_W-1:0] pix);
    int         rw;
    int         w;
    int         c;
    int         n;
    int         k;
    mean_word_t r;
    rw = eff_row();
    w = (win_cfg > WIN_CAP) ? WIN_CAP : int'(win_cfg);
    c = int'(col_cnt);
    k = 0;
    if (c >= rw) begin
      start_new_row();
      c = 0;
    end
    if (w == 0) begin
      r.mean = '0;
      r.last = 1'b1;
      owed_q.push_back(r);
      run_sum = '0;
      emitted = '0;
      col_cnt = (c + 1 == rw) ? 12'd0 : 12'(c + 1);
      return;
    end
    win_store[c % WIN_CAP] = pix;
    run_sum = run_sum + pix;
    n = c + 1 - int'(emitted);
    if (n >= w) begin
      retire_oldest(w);
      k++;
      n = c + 1 - int'(emitted);
    end
    if (c + 1 == rw) begin
      while (n > 0 && k < WIN_CAP) begin
        retire_oldest(n);
        k++;
        n--;
      end
      start_new_row();
    end else begin
      col_cnt = 12'(c + 1);
    end
    if (k > 0) begin
      r = owed_q.pop_back();
      r.last = 1'b1;
      owed_q.push_back(r);
    end
  endfunction

  task automatic write_reg(rbaf_pkg::reg_index_t idx, logic [rbaf_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == rbaf_pkg::REG_ROW_WIDTH) begin
      row_cfg = val[rbaf_pkg::ROW_W-1:0];
    end else begin
      win_cfg = val[rbaf_pkg::WIN_W-1:0];
    end
    start_new_row();
  endtask

  task automatic configure(int rw, int ws);
    write_reg(rbaf_pkg::REG_ROW_WIDTH, rbaf_pkg::CFG_W'(rw));
    write_reg(rbaf_pkg::REG_WINDOW_SIZE, rbaf_pkg::CFG_W'(ws));
  endtask

  task automatic drain();
    while (pix_q.size() != 0 || in_valid || owed_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // Sender: a gap drawn per word, waited out after that word is taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (tx_gap != 0) begin
        in_valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (pix_q.size() != 0) begin
        pixel_in <= pix_q.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 19) == 0) begin
          in_burst = !in_burst;
        end
        tx_gap <= in_burst ? 0 : $urandom_range(0, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait <= 0;
    end else begin
      if (out_took) begin
        if ($urandom_range(0, 19) == 0) begin
          out_burst = !out_burst;
        end
        rx_next = out_burst ? 0 : $urandom_range(0, 9);
      end else begin
        rx_next = (rx_wait > 0) ? rx_wait - 1 : 0;
      end
      rx_wait <= rx_next;
      out_stall <= (rx_next != 0) || (hold_left != 0);
    end
  end

  always @(posedge clk) begin
    mean_word_t want;
    in_took  <= !rst && in_valid && !in_stall;
    out_took <= !rst && out_valid && !out_stall;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("tb: unexpected word mean=%0d last=%0b", smudged_pixel, last_of_run);
          end
        end else begin
          want = owed_q.pop_front();
          if (want.mean !== smudged_pixel || want.last !== last_of_run) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("tb: mismatch at %0t: expected mean=%0d last=%0b, got mean=%0d last=%0b",
                       $realtime, want.mean, want.last, smudged_pixel, last_of_run);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_means(pixel_in);
      end
    end
  end

  initial begin
    int rw;
    int ws;
    int n;
    int eff;
    int rand_items;
    bit first;
    row_cfg = rbaf_pkg::ROW_WIDTH_RST;
    win_cfg = rbaf_pkg::WINDOW_SIZE_RST;
    start_new_row();
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Defaults, partial row that a later write drops.
    pix_q = {8'd0, 8'd255, 8'd128};
    drain();
    // Zero row width acts as one, oversized window saturates.
    configure(0, 31);
    pix_q = {8'd255, 8'd0};
    drain();
    // Zero window, wrapping at the row end.
    configure(3, 0);
    pix_q = {8'd7, 8'd200, 8'd255, 8'd1};
    drain();
    // Window wider than the row.
    configure(2, 5);
    pix_q = {8'd255, 8'd254};
    drain();
    // Oversized row width saturates.
    configure(8191, 1);
    pix_q = {8'd255, 8'd0, 8'd170, 8'd85};
    drain();
    configure(5, 2);
    pix_q = {8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
    drain();

    rand_items = 0;
    first = 1'b1;
    while (rand_items < 80) begin
      if (first) begin
        configure(WIDTH_CAP, WIN_CAP);
        n = 40;
      end else begin
        case ($urandom_range(0, 9))
          0: rw = $urandom_range(4097, 8191);
          1: rw = $urandom_range(0, 1);
          default: rw = $urandom_range(2, 16);
        endcase
        case ($urandom_range(0, 9))
          0: ws = 0;
          1: ws = $urandom_range(17, 31);
          2: ws = WIN_CAP;
          default: ws = $urandom_range(1, 8);
        endcase
        if ($urandom_range(0, 4) == 0) begin
          write_reg(rbaf_pkg::REG_WINDOW_SIZE, rbaf_pkg::CFG_W'(ws));
        end else begin
          configure(rw, ws);
        end
        eff = eff_row();
        if (eff > 16) begin
          n = $urandom_range(5, 20);
        end else if ($urandom_range(0, 3) == 0) begin
          n = $urandom_range(1, 2 * eff);
        end else begin
          n = eff * $urandom_range(1, 3);
        end
      end
      repeat (n) begin
        case ($urandom_range(0, 7))
          0: pix_q.push_back(8'd0);
          1: pix_q.push_back(8'd255);
          default: pix_q.push_back(rbaf_pkg::PIX_W'($urandom_range(0, 255)));
        endcase
      end
      if (first) begin
        holds_asked++;
        first = 1'b0;
      end
      rand_items += n;
      drain();
    end

    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
